// ----- design/ehpd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehpd_pkg
// Shared types, codes and constants of the exception-header pointer decoder.
// ----------------------------------------------------------------------------
package ehpd_pkg;

	localparam int VALUE_W         = 64;
	localparam int ENC_W           = 8;
	localparam int REG_INDEX_W     = 1;
	localparam int DEF_MAX_LEB     = 10;
	localparam int DEF_QUEUE_DEPTH = 4;

	localparam logic [REG_INDEX_W-1:0] REG_ENCODING = 1'b0;
	localparam logic [REG_INDEX_W-1:0] REG_FUNC_BASE = 1'b1;

	localparam logic [ENC_W-1:0] ENC_OMIT  = 8'hFF;
	localparam logic [ENC_W-1:0] ENC_RESET = 8'hFF;

	localparam logic [3:0] FMT_ABS  = 4'h0;
	localparam logic [3:0] FMT_ULEB = 4'h1;
	localparam logic [3:0] FMT_U2   = 4'h2;
	localparam logic [3:0] FMT_U4   = 4'h3;
	localparam logic [3:0] FMT_U8   = 4'h4;
	localparam logic [3:0] FMT_SLEB = 4'h9;
	localparam logic [3:0] FMT_S2   = 4'hA;
	localparam logic [3:0] FMT_S4   = 4'hB;
	localparam logic [3:0] FMT_S8   = 4'hC;

	localparam logic [2:0] RELOC_PC   = 3'h1;
	localparam logic [2:0] RELOC_FUNC = 3'h4;

	localparam logic [1:0] REL_NONE = 2'd0;
	localparam logic [1:0] REL_PC   = 2'd1;
	localparam logic [1:0] REL_FUNC = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_OMIT = 2'd1;
	localparam logic [1:0] ST_LONG = 2'd2;

	localparam logic [1:0] CMD_DATA = 2'd0;
	localparam logic [1:0] CMD_OMIT = 2'd1;
	localparam logic [1:0] CMD_LONG = 2'd2;

	typedef struct packed {
		logic [7:0]         data_byte;
		logic [VALUE_W-1:0] byte_address;
	} ehpd_byte_t;

	typedef struct packed {
		logic [VALUE_W-1:0] decoded_value;
		logic [1:0]         status;
	} ehpd_result_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic               first;
		logic               last;
		logic [7:0]         payload;
		logic [5:0]         shift;
		logic               shift_ok;
		logic               ext;
		logic [5:0]         ext_shift;
		logic [1:0]         rel;
		logic [VALUE_W-1:0] addr;
	} ehpd_cmd_t;

endpackage

// ----- design/dwarf_eh_pointer_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwarf_eh_pointer_decoder
// Byte-serial decoder of exception-header encoded pointers.
// A completed value passes from the queue through stage s1 into the output register.
// Throughput: one byte per cycle unless stalled; limited by the single accumulate stage.
// Reset: encoding reads omit, function base zero, queue and partial value empty.
// ----------------------------------------------------------------------------
module dwarf_eh_pointer_decoder #(
	parameter int MAX_LEB_BYTES = ehpd_pkg::DEF_MAX_LEB,
	parameter int QUEUE_DEPTH   = ehpd_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                write_enable,
	input  logic [ehpd_pkg::REG_INDEX_W-1:0]    write_index,
	input  logic [ehpd_pkg::VALUE_W-1:0]        write_data,
	input  logic                                byte_valid,
	output logic                                byte_stall,
	input  ehpd_pkg::ehpd_byte_t                byte_item,
	output logic                                result_valid,
	input  logic                                result_stall,
	output ehpd_pkg::ehpd_result_t              result_item
);
	import ehpd_pkg::*;

	logic [ENC_W-1:0]   encoding_q;
	logic [VALUE_W-1:0] func_base_q;
	logic               enc_write;
	logic               push;
	logic               q_pop;
	logic               q_full;
	logic               q_empty;
	ehpd_cmd_t          push_cmd;
	ehpd_cmd_t          pop_cmd;

	assign enc_write = write_enable && (write_index == REG_ENCODING);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			encoding_q  <= ENC_RESET;
			func_base_q <= '0;
		end else if (write_enable) begin
			if (write_index == REG_ENCODING) begin
				encoding_q <= write_data[ENC_W-1:0];
			end else if (write_index == REG_FUNC_BASE) begin
				func_base_q <= write_data;
			end
		end
	end

	ehpd_front #(
		.MAX_LEB_BYTES(MAX_LEB_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.encoding  (encoding_q),
		.clear     (enc_write),
		.byte_valid(byte_valid),
		.byte_item (byte_item),
		.q_full    (q_full),
		.byte_stall(byte_stall),
		.push      (push),
		.cmd       (push_cmd)
	);

	ehpd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_cmd),
		.pop      (q_pop),
		.pop_data (pop_cmd),
		.full     (q_full),
		.empty    (q_empty)
	);

	ehpd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.clear        (enc_write),
		.function_base(func_base_q),
		.q_empty      (q_empty),
		.q_data       (pop_cmd),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item)
	);

	// error results carry a zero value
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result_item.status != ST_OK) |-> result_item.decoded_value == '0)
		else $error("error result with nonzero value");

	// the queue is not empty in the cycle after a request is accepted
	assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && !byte_stall |=> !q_empty)
		else $error("accepted request missing from queue");

	// the queue is never popped while empty
	assert property (@(posedge clk) disable iff (!arst_n)
		q_empty |-> !q_pop)
		else $error("pop from empty queue");

endmodule

// ----- design/ehpd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehpd_front
// Takes bytes, tracks the byte position within a value and classifies each
// byte into a command for the accumulate stage.
// ----------------------------------------------------------------------------
module ehpd_front #(
	parameter int MAX_LEB_BYTES = ehpd_pkg::DEF_MAX_LEB
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [ehpd_pkg::ENC_W-1:0] encoding,
	input  logic                      clear,
	input  logic                      byte_valid,
	input  ehpd_pkg::ehpd_byte_t      byte_item,
	input  logic                      q_full,
	output logic                      byte_stall,
	output logic                      push,
	output ehpd_pkg::ehpd_cmd_t       cmd
);
	import ehpd_pkg::*;

	localparam int CNT_W = $clog2(MAX_LEB_BYTES);
	localparam int SH_W  = $clog2(7 * MAX_LEB_BYTES + 1);

	logic [CNT_W-1:0] taken_q;
	logic [CNT_W-1:0] taken_next;
	logic [CNT_W:0]   n;
	logic [SH_W-1:0]  sh_cur;
	logic [SH_W-1:0]  sh_end;
	logic [3:0]       fmt;
	logic [3:0]       fix_bytes;
	logic             supported;
	logic             is_leb;
	logic             is_signed;

	assign fmt        = encoding[3:0];
	assign is_signed  = fmt[3];
	assign byte_stall = q_full;
	assign push       = byte_valid && !q_full;
	assign n          = {1'b0, taken_q} + (CNT_W+1)'(1);
	assign sh_cur     = SH_W'(taken_q) * SH_W'(7);
	assign sh_end     = SH_W'(n) * SH_W'(7);

	always_comb begin
		supported = 1'b1;
		is_leb    = 1'b0;
		fix_bytes = 4'd8;
		unique case (fmt) inside
			FMT_ULEB, FMT_SLEB: begin
				is_leb = 1'b1;
			end
			FMT_U2, FMT_S2: begin
				fix_bytes = 4'd2;
			end
			FMT_U4, FMT_S4: begin
				fix_bytes = 4'd4;
			end
			FMT_ABS, FMT_U8, FMT_S8: begin
				fix_bytes = 4'd8;
			end
			default: begin
				supported = 1'b0;
			end
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.addr      = byte_item.byte_address;
		cmd.first     = (taken_q == '0);
		cmd.kind      = CMD_DATA;
		taken_next    = '0;
		if (encoding[6:4] == RELOC_PC) begin
			cmd.rel = REL_PC;
		end else if (encoding[6:4] == RELOC_FUNC) begin
			cmd.rel = REL_FUNC;
		end else begin
			cmd.rel = REL_NONE;
		end
		if (encoding == ENC_OMIT || !supported) begin
			cmd.kind = CMD_OMIT;
		end else if (is_leb) begin
			cmd.payload  = {1'b0, byte_item.data_byte[6:0]};
			cmd.shift    = sh_cur[5:0];
			cmd.shift_ok = (sh_cur < SH_W'(VALUE_W));
			if (byte_item.data_byte[7]) begin
				if (n >= (CNT_W+1)'(MAX_LEB_BYTES)) begin
					cmd.kind = CMD_LONG;
				end else begin
					taken_next = n[CNT_W-1:0];
				end
			end else begin
				cmd.last      = 1'b1;
				cmd.ext       = is_signed && (sh_end < SH_W'(VALUE_W))
					&& byte_item.data_byte[6];
				cmd.ext_shift = sh_end[5:0];
			end
		end else begin
			cmd.payload  = byte_item.data_byte;
			cmd.shift    = {taken_q[2:0], 3'b000};
			cmd.shift_ok = 1'b1;
			if (n >= (CNT_W+1)'(fix_bytes)) begin
				cmd.last      = 1'b1;
				cmd.ext       = is_signed && (fix_bytes != 4'd8) && byte_item.data_byte[7];
				cmd.ext_shift = {fix_bytes[2:0], 3'b000};
			end else begin
				taken_next = n[CNT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q <= '0;
		end else if (clear) begin
			taken_q <= '0;
		end else if (push) begin
			taken_q <= taken_next;
		end
	end

endmodule

// ----- design/ehpd_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehpd_queue
// Short command queue between the classify and accumulate parts.
// ----------------------------------------------------------------------------
module ehpd_queue #(
	parameter int DEPTH = ehpd_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ehpd_pkg::ehpd_cmd_t push_data,
	input  logic                pop,
	output ehpd_pkg::ehpd_cmd_t pop_data,
	output logic                full,
	output logic                empty
);
	import ehpd_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	ehpd_cmd_t        entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ----- design/ehpd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehpd_back
// Gathers value bits, applies sign extension, relocates and holds the result
// in an output register.
// ----------------------------------------------------------------------------
module ehpd_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               clear,
	input  logic [ehpd_pkg::VALUE_W-1:0]       function_base,
	input  logic                               q_empty,
	input  ehpd_pkg::ehpd_cmd_t                q_data,
	output logic                               q_pop,
	output logic                               result_valid,
	input  logic                               result_stall,
	output ehpd_pkg::ehpd_result_t             result_item
);
	import ehpd_pkg::*;

	logic [VALUE_W-1:0] acc_q;
	logic [VALUE_W-1:0] start_q;
	logic [VALUE_W-1:0] acc_n;
	logic [VALUE_W-1:0] start_n;
	logic [VALUE_W-1:0] ext_mask;
	logic               emit;

	logic               valid_s1;
	logic [VALUE_W-1:0] value_s1;
	logic [VALUE_W-1:0] addend_s1;
	logic [1:0]         status_s1;

	logic               out_valid_q;
	ehpd_result_t       out_q;
	logic               advance;
	logic               s1_free;

	assign advance      = !out_valid_q || !result_stall;
	assign s1_free      = !valid_s1 || advance;
	assign q_pop        = !q_empty && s1_free;
	assign emit         = (q_data.kind != CMD_DATA) || q_data.last;
	assign result_valid = out_valid_q;
	assign result_item  = out_q;

	always_comb begin
		acc_n = acc_q;
		if (q_data.shift_ok) begin
			acc_n = acc_q | (VALUE_W'(q_data.payload) << q_data.shift);
		end
		ext_mask = '0;
		if (q_data.ext) begin
			ext_mask = {VALUE_W{1'b1}} << q_data.ext_shift;
		end
		start_n = q_data.first ? q_data.addr : start_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			start_q <= '0;
		end else if (clear) begin
			acc_q   <= '0;
			start_q <= '0;
		end else if (q_pop) begin
			if (emit) begin
				acc_q   <= '0;
				start_q <= '0;
			end else begin
				acc_q   <= acc_n;
				start_q <= start_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= q_pop && emit;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && emit) begin
			unique case (q_data.kind)
				CMD_OMIT: begin
					status_s1 <= ST_OMIT;
					value_s1  <= '0;
					addend_s1 <= '0;
				end
				CMD_LONG: begin
					status_s1 <= ST_LONG;
					value_s1  <= '0;
					addend_s1 <= '0;
				end
				default: begin
					status_s1 <= ST_OK;
					value_s1  <= acc_n | ext_mask;
					if (q_data.rel == REL_PC) begin
						addend_s1 <= start_n;
					end else if (q_data.rel == REL_FUNC) begin
						addend_s1 <= function_base;
					end else begin
						addend_s1 <= '0;
					end
				end
			endcase
		end
		if (advance && valid_s1) begin
			out_q.status        <= status_s1;
			out_q.decoded_value <= (value_s1 == '0) ? '0 : value_s1 + addend_s1;
		end
	end

endmodule
